// ===== hdl/joystick_axis_conditioner_top_macros.svh =====
// Assertion macros shared by the joystick axis conditioner RTL.
// No dependencies; define ASSERT_OFF to drop every check.
`ifndef JOYSTICK_AXIS_CONDITIONER_TOP_MACROS_SVH
`define JOYSTICK_AXIS_CONDITIONER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/jac_pkg.sv =====
// Shared widths, reset values and word types of the joystick axis conditioner.
// No dependencies.
package jac_pkg;

    localparam int SAMPLE_BITS     = 12;
    localparam int FRAC_BITS       = 8;
    localparam int AVG_W           = SAMPLE_BITS + FRAC_BITS;
    localparam int GAIN_W          = 9;
    localparam int DEAD_W          = 12;
    localparam int PCT_W           = 8;
    localparam int PCT_FULL        = 100;
    localparam int CAL_SAMPLES_DEF = 25;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_GAIN = 2'd1;

    localparam logic [SAMPLE_BITS-1:0] RESET_CENTER = 12'd2000;
    localparam logic [DEAD_W-1:0]      DEAD_RESET   = 12'd100;
    localparam logic [GAIN_W-1:0]      GAIN_RESET   = 9'd26;
    localparam logic [GAIN_W-1:0]      GAIN_ONE     = 9'd256;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_x;
        logic [SAMPLE_BITS-1:0] sample_y;
    } t_in_word;

    typedef struct packed {
        logic signed [PCT_W-1:0] pos_x;
        logic signed [PCT_W-1:0] pos_y;
        logic                    calibrating;
    } t_out_word;

endpackage

// ===== hdl/jac_axis_pct.sv =====
// Per-axis percent conversion: center offset, dead band, scale and saturate.
// Depends on jac_pkg.
module jac_axis_pct import jac_pkg::*; (
    input  logic [AVG_W-1:0]        i_avg,
    input  logic [SAMPLE_BITS-1:0]  i_center,
    input  logic [DEAD_W-1:0]       i_dead_band,
    output logic signed [PCT_W-1:0] o_pct
);

    localparam int SCALED_W = SAMPLE_BITS + 7;

    logic signed [SAMPLE_BITS:0] off;
    logic [SAMPLE_BITS-1:0]      mag;
    logic [SCALED_W-1:0]         scaled;
    logic [PCT_W-1:0]            quo;
    logic [PCT_W-1:0]            sat;

    always_comb begin
        off    = $signed({1'b0, i_avg[AVG_W-1:FRAC_BITS]}) - $signed({1'b0, i_center});
        mag    = off[SAMPLE_BITS] ? SAMPLE_BITS'(-off) : off[SAMPLE_BITS-1:0];
        scaled = SCALED_W'(mag) * SCALED_W'(PCT_FULL);
        quo    = scaled[SAMPLE_BITS-1 +: PCT_W];
        sat    = (quo > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : quo;
        if (SAMPLE_BITS'(mag) < SAMPLE_BITS'(i_dead_band)) begin
            o_pct = '0;
        end else if (off[SAMPLE_BITS]) begin
            o_pct = -$signed(sat);
        end else begin
            o_pct = $signed(sat);
        end
    end

endmodule

// ===== hdl/joystick_axis_conditioner_top.sv =====
// An accepted input word passes the input register, then moving average (gain multiply)
// and percent logic, or center calibration, into the output register. Throughput: one
// word per cycle; an output stall holds both registers.
// Reset (synchronous, active low): empties the pipeline, restarts center calibration,
// sets centers and averages to 2000 and the dead band and gain to 100 and 26.
// Depends on jac_pkg, jac_axis_pct and joystick_axis_conditioner_top_macros.svh.
`include "joystick_axis_conditioner_top_macros.svh"
module joystick_axis_conditioner_top import jac_pkg::*; #(
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DEAD_W-1:0]    i_cfg_data
);

    localparam int CNT_W    = $clog2(CAL_SAMPLES + 1);
    localparam int SUM_W    = SAMPLE_BITS + CNT_W;
    localparam int RECIP_SH = SUM_W + $clog2(CAL_SAMPLES);
    localparam int RECIP_W  = SUM_W + 1;
    localparam int QUOT_W   = SUM_W + RECIP_W;
    localparam int PROD_W   = AVG_W + GAIN_W + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((longint'(1) << RECIP_SH) + longint'(CAL_SAMPLES) - 1) / CAL_SAMPLES);
    localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(CAL_SAMPLES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAL_SAMPLES - 1);
    localparam logic [AVG_W-1:0] AVG_RESET = {RESET_CENTER, FRAC_BITS'(0)};
    localparam logic signed [PCT_W-1:0] PCT_MAX = PCT_W'(PCT_FULL);
    localparam logic signed [PCT_W-1:0] PCT_MIN = -PCT_W'(PCT_FULL);

    function automatic logic [AVG_W-1:0] ema_next(
        input logic [AVG_W-1:0]       avg,
        input logic [SAMPLE_BITS-1:0] sample,
        input logic [GAIN_W-1:0]      gain
    );
        logic [GAIN_W-1:0]        g;
        logic signed [AVG_W:0]    diff;
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] step;
        logic signed [PROD_W-1:0] sum;
        g    = (gain > GAIN_ONE) ? GAIN_ONE : gain;
        diff = $signed({1'b0, sample, FRAC_BITS'(0)}) - $signed({1'b0, avg});
        prod = PROD_W'($signed({1'b0, g})) * PROD_W'(diff);
        step = prod >>> FRAC_BITS;
        sum  = step + $signed({(PROD_W - AVG_W)'(0), avg});
        return sum[AVG_W-1:0];
    endfunction

    logic                   en;
    logic                   s1_cal;
    logic                   s1_last;
    logic [SUM_W-1:0]       n_sum_x;
    logic [SUM_W-1:0]       n_sum_y;
    logic [QUOT_W-1:0]      quot_x;
    logic [QUOT_W-1:0]      quot_y;
    logic [AVG_W-1:0]       n_avg_x;
    logic [AVG_W-1:0]       n_avg_y;
    logic signed [PCT_W-1:0] pct_x;
    logic signed [PCT_W-1:0] pct_y;
    t_out_word              n_out_word;
    logic                   out_zero;
    logic                   pct_ok;

    logic                   r_s1_valid;
    t_in_word               r_s1_word;
    logic [CNT_W-1:0]       r_cal_count;
    logic [SUM_W-1:0]       r_sum_x;
    logic [SUM_W-1:0]       r_sum_y;
    logic [SAMPLE_BITS-1:0] r_center_x;
    logic [SAMPLE_BITS-1:0] r_center_y;
    logic [AVG_W-1:0]       r_avg_x;
    logic [AVG_W-1:0]       r_avg_y;
    logic [DEAD_W-1:0]      r_dead_band;
    logic [GAIN_W-1:0]      r_gain;
    logic                   r_out_valid;
    t_out_word              r_out_word;

    assign en          = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        s1_cal  = r_cal_count < CNT_DONE;
        s1_last = r_cal_count == CNT_LAST;
        n_sum_x = r_sum_x + SUM_W'(r_s1_word.sample_x);
        n_sum_y = r_sum_y + SUM_W'(r_s1_word.sample_y);
        quot_x  = QUOT_W'(n_sum_x) * QUOT_W'(RECIP);
        quot_y  = QUOT_W'(n_sum_y) * QUOT_W'(RECIP);
        n_avg_x = ema_next(r_avg_x, r_s1_word.sample_x, r_gain);
        n_avg_y = ema_next(r_avg_y, r_s1_word.sample_y, r_gain);
    end

    jac_axis_pct u_pct_x (
        .i_avg       (n_avg_x),
        .i_center    (r_center_x),
        .i_dead_band (r_dead_band),
        .o_pct       (pct_x)
    );

    jac_axis_pct u_pct_y (
        .i_avg       (n_avg_y),
        .i_center    (r_center_y),
        .i_dead_band (r_dead_band),
        .o_pct       (pct_y)
    );

    always_comb begin
        if (s1_cal) begin
            n_out_word.pos_x       = '0;
            n_out_word.pos_y       = '0;
            n_out_word.calibrating = 1'b1;
        end else begin
            n_out_word.pos_x       = pct_x;
            n_out_word.pos_y       = pct_y;
            n_out_word.calibrating = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cal_count <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_center_x  <= RESET_CENTER;
            r_center_y  <= RESET_CENTER;
            r_avg_x     <= AVG_RESET;
            r_avg_y     <= AVG_RESET;
            r_dead_band <= DEAD_RESET;
            r_gain      <= GAIN_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEAD_BAND:      r_dead_band <= i_cfg_data;
                    CFG_SMOOTHING_GAIN: r_gain      <= i_cfg_data[GAIN_W-1:0];
                    default:            ;
                endcase
            end
            if (en) begin
                r_s1_valid  <= i_in_valid;
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    if (s1_cal) begin
                        r_sum_x     <= n_sum_x;
                        r_sum_y     <= n_sum_y;
                        r_cal_count <= r_cal_count + 1'b1;
                        if (s1_last) begin
                            r_center_x <= quot_x[RECIP_SH +: SAMPLE_BITS];
                            r_center_y <= quot_y[RECIP_SH +: SAMPLE_BITS];
                        end
                    end else begin
                        r_avg_x <= n_avg_x;
                        r_avg_y <= n_avg_y;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (i_in_valid) begin
                r_s1_word <= i_in_word;
            end
            if (r_s1_valid) begin
                r_out_word <= n_out_word;
            end
        end
    end

    assign out_zero = (o_out_word.pos_x == '0) && (o_out_word.pos_y == '0);
    assign pct_ok   = o_out_word.pos_x <= PCT_MAX && o_out_word.pos_x >= PCT_MIN &&
                      o_out_word.pos_y <= PCT_MAX && o_out_word.pos_y >= PCT_MIN;

    `ASSERT_IMPLIES(a_cal_zero, i_clk, i_rst_n, o_out_valid && o_out_word.calibrating, out_zero)
    `ASSERT_IMPLIES(a_pct_range, i_clk, i_rst_n, o_out_valid && !o_out_word.calibrating, pct_ok)
    `ASSERT_NEXT(a_cal_done_holds, i_clk, i_rst_n, r_cal_count == CNT_DONE, r_cal_count == CNT_DONE)
    `ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_s1_valid)

endmodule

// ===== tb/joystick_position_checker.sv =====
// Checker for the joystick axis conditioner: watches the config, sample and result channels,
// predicts each result word from its own copy of calibration, averages and registers.
// Depends on jac_pkg.
module joystick_position_checker import jac_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_word             i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_word            i_out_word,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DEAD_W-1:0]    i_cfg_data,
    output int                   o_pending,
    output int                   o_failures
);

    localparam int REPORT_MAX = 10;

    logic [DEAD_W-1:0]      dead_band;
    logic [GAIN_W-1:0]      gain;
    int                     cal_seen;
    logic [16:0]            sum_x;
    logic [16:0]            sum_y;
    logic [SAMPLE_BITS-1:0] center_x;
    logic [SAMPLE_BITS-1:0] center_y;
    logic [AVG_W-1:0]       avg_x;
    logic [AVG_W-1:0]       avg_y;
    t_out_word              positions_due[$];
    int                     failures = 0;
    int                     results_checked = 0;

    function automatic logic [AVG_W-1:0] ema_next(logic [AVG_W-1:0] avg,
                                                  logic [SAMPLE_BITS-1:0] s);
        longint g;
        longint diff;
        longint nxt;
        longint top;
        g    = longint'((gain > GAIN_ONE) ? GAIN_ONE : gain);
        diff = longint'({s, 8'h00}) - longint'(avg);
        nxt  = longint'(avg) + ((g * diff) >>> FRAC_BITS);
        top  = (longint'(1) << AVG_W) - 1;
        if (nxt < 0)
            nxt = 0;
        if (nxt > top)
            nxt = top;
        return nxt[AVG_W-1:0];
    endfunction

    function automatic logic signed [PCT_W-1:0] percent_of(logic [AVG_W-1:0] avg,
                                                           logic [SAMPLE_BITS-1:0] center);
        int off;
        int mag;
        int pct;
        off = int'(avg[AVG_W-1:FRAC_BITS]) - int'(center);
        mag = (off < 0) ? -off : off;
        if (mag < int'(dead_band))
            return '0;
        pct = (off * PCT_FULL) / (1 << (SAMPLE_BITS - 1));
        if (pct > PCT_FULL)
            pct = PCT_FULL;
        if (pct < -PCT_FULL)
            pct = -PCT_FULL;
        return pct[PCT_W-1:0];
    endfunction

    function automatic t_out_word condition_pair(t_in_word w);
        t_out_word r;
        r = '0;
        if (cal_seen < CAL_SAMPLES_DEF) begin
            sum_x = sum_x + 17'(w.sample_x);
            sum_y = sum_y + 17'(w.sample_y);
            cal_seen++;
            if (cal_seen == CAL_SAMPLES_DEF) begin
                center_x = SAMPLE_BITS'(sum_x / CAL_SAMPLES_DEF);
                center_y = SAMPLE_BITS'(sum_y / CAL_SAMPLES_DEF);
            end
            r.calibrating = 1'b1;
        end else begin
            avg_x   = ema_next(avg_x, w.sample_x);
            avg_y   = ema_next(avg_y, w.sample_y);
            r.pos_x = percent_of(avg_x, center_x);
            r.pos_y = percent_of(avg_y, center_y);
        end
        return r;
    endfunction

    task automatic check_position(t_out_word got);
        t_out_word due;
        results_checked++;
        if (positions_due.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
                $display("result word %0d arrived with no sample pair pending: x=%0d y=%0d cal=%0b",
                         results_checked, got.pos_x, got.pos_y, got.calibrating);
        end else begin
            due = positions_due.pop_front();
            if (got.pos_x !== due.pos_x || got.pos_y !== due.pos_y ||
                got.calibrating !== due.calibrating) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("result word %0d: expected x=%0d y=%0d cal=%0b, got x=%0d y=%0d cal=%0b",
                             results_checked, due.pos_x, due.pos_y, due.calibrating,
                             got.pos_x, got.pos_y, got.calibrating);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dead_band = DEAD_RESET;
            gain      = GAIN_RESET;
            cal_seen  = 0;
            sum_x     = '0;
            sum_y     = '0;
            center_x  = RESET_CENTER;
            center_y  = RESET_CENTER;
            avg_x     = {RESET_CENTER, 8'h00};
            avg_y     = {RESET_CENTER, 8'h00};
            positions_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEAD_BAND:      dead_band = i_cfg_data;
                    CFG_SMOOTHING_GAIN: gain = i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall)
                check_position(i_out_word);
            if (i_in_valid && !i_in_stall)
                positions_due.push_back(condition_pair(i_in_word));
        end
        o_pending  <= positions_due.size();
        o_failures <= failures;
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the joystick axis conditioner testbench: clock, reset, register settings,
// sample pairs and random back-pressure; the checker module does all prediction.
// Depends on jac_pkg, joystick_position_checker and joystick_axis_conditioner_top.
module tb_top;
    import jac_pkg::*;

    localparam int PHASES          = 10;
    localparam int PRESSURE_PHASE  = 4;
    localparam int HOLD_CYCLES     = 80;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int IDLE_PCT        = 34;
    localparam int CENTER_SEEN     = 2047;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in_word             in_word = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_word            out_word;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_DEAD_BAND;
    logic [DEAD_W-1:0]    cfg_data = '0;

    bit gaps_on = 1'b1;
    bit hold_off_go = 1'b0;
    int pending;
    int failures;
    int pairs_sent = 0;
    int settings = 0;
    int results_seen = 0;
    int backed_up = 0;
    int quiet = 0;
    int aim [2] = '{2048, 2048};

    int dead_tab [PHASES] = '{100, 4095, 2048, 0, 50, 1, -1, -1, -1, 200};
    int gain_tab [PHASES] = '{26, 256, 511, 0, 128, 1, -1, -1, -1, 257};
    int len_tab  [PHASES] = '{120, 40, 40, 40, 120, 60, 60, 60, 60, 60};

    joystick_axis_conditioner_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    joystick_position_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_word   (in_word),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_failures  (failures)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(int axis);
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 8)
            aim[axis] = $urandom_range(4095);
        else if (r < 14)
            return (r < 11) ? '0 : '1;
        else if (r < 24)
            return SAMPLE_BITS'($urandom_range(4095));
        v = aim[axis] + int'($urandom_range(16)) - 8;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[SAMPLE_BITS-1:0];
    endfunction

    task automatic put_pair(input logic [SAMPLE_BITS-1:0] x, input logic [SAMPLE_BITS-1:0] y);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{sample_x: x, sample_y: y};
        do @(posedge clk); while (in_stall);
        pairs_sent++;
    endtask

    task automatic set_config(input logic [DEAD_W-1:0] dead, input logic [GAIN_W-1:0] g);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DEAD_BAND;
        cfg_data  <= dead;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_SMOOTHING_GAIN;
        cfg_data  <= DEAD_W'(g);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : receiver
        bit held;
        held = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_go && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (in_valid && in_stall)
            backed_up <= backed_up + 1;
        if (out_valid && !out_stall)
            results_seen <= results_seen + 1;
        if (quiet >= WATCHDOG_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int p;
        int n;
        logic [DEAD_W-1:0] dead;
        logic [GAIN_W-1:0] g;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put_pair('0, '1);
        put_pair('1, '0);
        put_pair(12'hAAA, 12'h555);
        put_pair(12'h555, 12'hAAA);
        for (n = 4; n < CAL_SAMPLES_DEF; n++)
            put_pair(12'd2048, 12'd2048);
        drain();

        set_config(DEAD_RESET, GAIN_ONE);
        put_pair('0, '1);
        put_pair('1, '0);
        put_pair(SAMPLE_BITS'(CENTER_SEEN + 99), SAMPLE_BITS'(CENTER_SEEN - 99));
        put_pair(SAMPLE_BITS'(CENTER_SEEN + 100), SAMPLE_BITS'(CENTER_SEEN - 100));
        put_pair(SAMPLE_BITS'(CENTER_SEEN - 100), SAMPLE_BITS'(CENTER_SEEN + 100));
        put_pair(SAMPLE_BITS'(CENTER_SEEN - 99), SAMPLE_BITS'(CENTER_SEEN + 99));
        put_pair(SAMPLE_BITS'(CENTER_SEEN), SAMPLE_BITS'(CENTER_SEEN));
        drain();

        for (p = 0; p < PHASES; p++) begin
            dead = DEAD_W'((dead_tab[p] < 0) ? $urandom_range(4095) : dead_tab[p]);
            g    = GAIN_W'((gain_tab[p] < 0) ? $urandom_range(511) : gain_tab[p]);
            gaps_on     <= (p != PRESSURE_PHASE);
            hold_off_go <= (p == PRESSURE_PHASE);
            set_config(dead, g);
            for (n = 0; n < len_tab[p]; n++)
                put_pair(pick_sample(0), pick_sample(1));
            drain();
        end

        $display("Sent %0d sample pairs across %0d register settings, checked %0d result words;",
                 pairs_sent, settings, results_seen);
        $display("input side was held off for %0d cycles while the output backed up.",
                 backed_up);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
